// ===== sv/nls_pkg.sv =====
// Package for the nearest landmark search: sizes, landmark table, and the
// record types passed along the distance cells and the square root cells.
// Depends on nothing; used by every other file of the block.
`default_nettype none

package nls_pkg;

  // Landmark table: five named entries, the rest of the table at the origin
  localparam int LANDMARK_COUNT = 5;
  localparam int TABLE_SIZE     = 64;
  localparam int CELL_COUNT     = (LANDMARK_COUNT > TABLE_SIZE) ? TABLE_SIZE : LANDMARK_COUNT;
  localparam int IDX_W          = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  // Field and datapath widths
  localparam int POS_W     = 16;             // Q8.8 position
  localparam int DIFF_W    = POS_W + 1;      // exact coordinate difference
  localparam int SQR_W     = 2 * POS_W;      // one squared difference
  localparam int SQ_W      = SQR_W + 1;      // sum of two squares
  localparam int ROOT_W    = (SQ_W + 1) / 2; // root bits, one per cell
  localparam int RAD_W     = 2 * ROOT_W;     // radicand padded to whole digit pairs
  localparam int REM_W     = ROOT_W + 2;     // partial remainder
  localparam int OUT_IDX_W = 3;
  localparam int DIST_W    = 17;

  // Pipeline depth: two stages per distance cell, one per root bit
  localparam int LATENCY = 2 * CELL_COUNT + ROOT_W;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [OUT_IDX_W-1:0]    out_idx_t;
  typedef logic [DIST_W-1:0]       dist_t;

  // Running best candidate handed from one distance cell to the next
  typedef struct packed {
    pos_t            px;
    pos_t            py;
    logic            found;
    idx_t            idx;
    logic [SQ_W-1:0] sq;
  } cand_t;

  // Square root work record handed from one root cell to the next
  typedef struct packed {
    idx_t              idx;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } root_t;

  // Landmark x coordinates, Q8.8 meters
  function automatic pos_t mark_x(input int i);
    case (i)
      0:       return pos_t'(79);
      1:       return pos_t'(28);
      2:       return pos_t'(-292);
      3:       return pos_t'(-663);
      4:       return pos_t'(-23);
      default: return pos_t'(0);
    endcase
  endfunction

  // Landmark y coordinates, Q8.8 meters
  function automatic pos_t mark_y(input int i);
    case (i)
      0:       return pos_t'(-253);
      1:       return pos_t'(-620);
      2:       return pos_t'(-737);
      3:       return pos_t'(-212);
      4:       return pos_t'(136);
      default: return pos_t'(0);
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== sv/nearest_landmark_search.sv =====
// Nearest landmark search: a position goes in on start, passes through the
// registered distance cells, one per landmark, and then the root cells, one per
// root bit (17 bits); done then pulses for one cycle with the nearest landmark's
// index and its floored Euclidean distance in Q8.8. The pipeline takes one
// transaction every cycle, so busy stays low; the receiver has no way to stall
// and must take each result in the cycle done is high. Equal distances go to
// the lower index. Depends on nls_pkg, nls_cell and nls_root_cell.
`default_nettype none

module nearest_landmark_search (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [15:0]        position_x,
  input  logic signed [15:0]        position_y,
  output logic                      done,
  output logic [2:0]                landmark_index,
  output logic [16:0]               distance
);

  logic           cvld  [nls_pkg::CELL_COUNT+1];
  nls_pkg::cand_t ccand [nls_pkg::CELL_COUNT+1];
  logic           rvld  [nls_pkg::ROOT_W+1];
  nls_pkg::root_t rwork [nls_pkg::ROOT_W+1];

  // Pipeline never stalls
  assign busy = 1'b0;

  // Chain entry: no candidate yet
  always_comb begin
    cvld[0]        = start;
    ccand[0].px    = position_x;
    ccand[0].py    = position_y;
    ccand[0].found = 1'b0;
    ccand[0].idx   = '0;
    ccand[0].sq    = '0;
  end

  // Row of distance cells, one per landmark
  for (genvar i = 0; i < nls_pkg::CELL_COUNT; i++) begin : g_cell
    nls_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .vld_in   (cvld[i]),
      .cand_in  (ccand[i]),
      .mark_x   (nls_pkg::mark_x(i)),
      .mark_y   (nls_pkg::mark_y(i)),
      .cell_idx (nls_pkg::idx_t'(i)),
      .vld_out  (cvld[i+1]),
      .cand_out (ccand[i+1])
    );
  end

  // Root entry: best squared distance, zero when no landmark was searched
  always_comb begin
    rvld[0]       = cvld[nls_pkg::CELL_COUNT];
    rwork[0].idx  = ccand[nls_pkg::CELL_COUNT].idx;
    rwork[0].rad  = {{(nls_pkg::RAD_W - nls_pkg::SQ_W){1'b0}}, ccand[nls_pkg::CELL_COUNT].sq};
    rwork[0].rem  = '0;
    rwork[0].root = '0;
  end

  // Row of root cells, one per result bit
  for (genvar j = 0; j < nls_pkg::ROOT_W; j++) begin : g_root
    nls_root_cell u_root (
      .clk      (clk),
      .rst      (rst),
      .vld_in   (rvld[j]),
      .work_in  (rwork[j]),
      .vld_out  (rvld[j+1]),
      .work_out (rwork[j+1])
    );
  end

  // Result ports straight from the last root cell
  assign done           = rvld[nls_pkg::ROOT_W];
  assign landmark_index = nls_pkg::out_idx_t'(rwork[nls_pkg::ROOT_W].idx);
  assign distance       = nls_pkg::dist_t'(rwork[nls_pkg::ROOT_W].root);

`ifndef SYNTH
  // Every accepted transaction yields its result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(nls_pkg::LATENCY) done)
    else $error("result missing after pipeline latency");

  // A position on the first landmark is at distance zero
  a_on_mark: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && position_x == nls_pkg::mark_x(0) && position_y == nls_pkg::mark_y(0))
      |-> ##(nls_pkg::LATENCY) (distance == '0))
    else $error("nonzero distance on a landmark");

  // Floored root: final remainder never exceeds twice the root
  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    done |-> (rwork[nls_pkg::ROOT_W].rem <= {1'b0, rwork[nls_pkg::ROOT_W].root, 1'b0}))
    else $error("square root remainder out of range");
`endif

endmodule

`default_nettype wire

// ===== sv/nls_cell.sv =====
// One distance cell: squared distance to its landmark and keep-the-nearest.
// Depends on nls_pkg for the candidate record and widths.
`default_nettype none

module nls_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                vld_in,
  input  nls_pkg::cand_t      cand_in,
  input  nls_pkg::pos_t       mark_x,
  input  nls_pkg::pos_t       mark_y,
  input  nls_pkg::idx_t       cell_idx,
  output logic                vld_out,
  output nls_pkg::cand_t      cand_out
);

  logic signed [nls_pkg::DIFF_W-1:0]   dx;
  logic signed [nls_pkg::DIFF_W-1:0]   dy;
  logic signed [2*nls_pkg::DIFF_W-1:0] dx_prod;
  logic signed [2*nls_pkg::DIFF_W-1:0] dy_prod;

  logic                       s1_vld;
  nls_pkg::cand_t             s1_cand;
  logic [nls_pkg::SQR_W-1:0]  dx2;
  logic [nls_pkg::SQR_W-1:0]  dy2;

  logic [nls_pkg::SQ_W-1:0]   sum;
  logic                       take;

  // Stage 1: differences and squares
  always_comb begin
    dx      = {mark_x[nls_pkg::POS_W-1], mark_x} - {cand_in.px[nls_pkg::POS_W-1], cand_in.px};
    dy      = {mark_y[nls_pkg::POS_W-1], mark_y} - {cand_in.py[nls_pkg::POS_W-1], cand_in.py};
    dx_prod = (2*nls_pkg::DIFF_W)'(dx) * (2*nls_pkg::DIFF_W)'(dx);
    dy_prod = (2*nls_pkg::DIFF_W)'(dy) * (2*nls_pkg::DIFF_W)'(dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    s1_cand <= cand_in;
    dx2     <= dx_prod[nls_pkg::SQR_W-1:0];
    dy2     <= dy_prod[nls_pkg::SQR_W-1:0];
  end

  // Stage 2: sum and strict less-than against the running best
  always_comb begin
    sum  = {1'b0, dx2} + {1'b0, dy2};
    take = !s1_cand.found || (sum < s1_cand.sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    cand_out.px    <= s1_cand.px;
    cand_out.py    <= s1_cand.py;
    cand_out.found <= 1'b1;
    cand_out.idx   <= take ? cell_idx : s1_cand.idx;
    cand_out.sq    <= take ? sum : s1_cand.sq;
  end

endmodule

`default_nettype wire

// ===== sv/nls_root_cell.sv =====
// One square root cell: settles one bit of the floored root per cycle.
// Depends on nls_pkg for the root record and widths.
`default_nettype none

module nls_root_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           vld_in,
  input  nls_pkg::root_t work_in,
  output logic           vld_out,
  output nls_pkg::root_t work_out
);

  logic [nls_pkg::REM_W-1:0] rem_sh;
  logic [nls_pkg::REM_W-1:0] trial;
  logic                      fits;

  // Bring down the next digit pair and try root bit one
  always_comb begin
    rem_sh = {work_in.rem[nls_pkg::REM_W-3:0], work_in.rad[nls_pkg::RAD_W-1 -: 2]};
    trial  = {work_in.root, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    work_out.idx  <= work_in.idx;
    work_out.rad  <= {work_in.rad[nls_pkg::RAD_W-3:0], 2'b00};
    work_out.rem  <= fits ? (rem_sh - trial) : rem_sh;
    work_out.root <= {work_in.root[nls_pkg::ROOT_W-2:0], fits};
  end

endmodule

`default_nettype wire

// ===== tb/nearest_landmark_search_checker.sv =====
// Checker for the nearest landmark search: watches the command and result
// ports, predicts index and floored distance per position, and counts mismatches.
// Depends on nls_pkg for field types and the landmark count.
`default_nettype none

module nearest_landmark_search_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  nls_pkg::pos_t       position_x,
  input  nls_pkg::pos_t       position_y,
  input  logic                done,
  input  nls_pkg::out_idx_t   landmark_index,
  input  nls_pkg::dist_t      distance,
  output int                  fail_count,
  output int                  pending
);
  import nls_pkg::*;

  typedef struct {
    out_idx_t idx;
    dist_t    range_q88;
  } hit_t;

  // Landmark positions in Q8.8: cube, dumpster, cylinder, barrier, bookshelf
  localparam int SITE_X [5] = '{79, 28, -292, -663, -23};
  localparam int SITE_Y [5] = '{-253, -620, -737, -212, 136};

  hit_t hits_q [$];

  initial fail_count = 0;
  initial pending = 0;

  // Floored square root, one result bit per pass
  function automatic dist_t floor_root(input longint unsigned sq);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sq) root = trial;
    end
    return dist_t'(root);
  endfunction

  // Scan the table; strict less-than keeps the earliest of equal distances
  function automatic hit_t nearest_site(input pos_t px, input pos_t py);
    hit_t            hit;
    longint          dx;
    longint          dy;
    longint unsigned sq;
    longint unsigned best_sq;
    int              best;
    best    = 0;
    best_sq = 0;
    for (int i = 0; i < CELL_COUNT; i++) begin
      dx = longint'((i < 5) ? SITE_X[i] : 0) - longint'(px);
      dy = longint'((i < 5) ? SITE_Y[i] : 0) - longint'(py);
      sq = longint'(dx * dx + dy * dy);
      if (i == 0 || sq < best_sq) begin
        best_sq = sq;
        best    = i;
      end
    end
    hit.idx       = out_idx_t'(best);
    hit.range_q88 = (CELL_COUNT > 0) ? floor_root(best_sq) : '0;
    return hit;
  endfunction

  task automatic report(input string field, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, field, got, want);
    fail_count++;
  endtask

  // Queue a prediction per accepted transaction, check each result strobe
  always @(posedge clk) begin
    hit_t want;
    if (!rst) begin
      if (start && !busy) hits_q = {hits_q, nearest_site(position_x, position_y)};
      if (done !== 1'b0) begin
        if (hits_q.size() == 0) begin
          report("unexpected result", longint'(landmark_index), -1);
        end else begin
          want = hits_q.pop_front();
          if (landmark_index !== want.idx)
            report("landmark_index", longint'(landmark_index), longint'(want.idx));
          if (distance !== want.range_q88)
            report("distance", longint'(distance), longint'(want.range_q88));
        end
      end
    end
    pending = hits_q.size();
  end

endmodule

`default_nettype wire

// ===== tb/nearest_landmark_search_tb.sv =====
// Testbench top for the nearest landmark search: clock, reset, position
// stimulus with random gaps, and the verdict. Depends on nls_pkg, the block,
// and nearest_landmark_search_checker, which does all prediction and checks.
`default_nettype none

module nearest_landmark_search_tb;
  import nls_pkg::*;

  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 200000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  pos_t     position_x = '0;
  pos_t     position_y = '0;
  logic     done;
  out_idx_t landmark_index;
  dist_t    distance;
  int       fail_count;
  int       pending;
  int       cycles = 0;
  int       burst_left = 0;

  always #6 clk = ~clk;

  nearest_landmark_search uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .position_x     (position_x),
    .position_y     (position_y),
    .done           (done),
    .landmark_index (landmark_index),
    .distance       (distance)
  );

  nearest_landmark_search_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .position_x     (position_x),
    .position_y     (position_y),
    .done           (done),
    .landmark_index (landmark_index),
    .distance       (distance),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // Hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_position(input int x, input int y);
    start      <= 1'b1;
    position_x <= pos_t'(x);
    position_y <= pos_t'(y);
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // Idle cycles between transactions: mostly none or short, some long, with bursts
  task automatic idle_gap();
    int r;
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        burst_left = $urandom_range(20, 60);
        gap = 0;
      end else if (r < 50) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Random coordinate: full range, near the origin, landmark neighborhood, or an extreme value
  function automatic int pick_coord(input int site);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return int'($signed(16'($urandom())));
    if (r < 80) return $urandom_range(0, 3000) - 1500;
    if (r < 92) return site + $urandom_range(0, 16) - 8;
    case ($urandom_range(0, 3))
      0:       return -32768;
      1:       return 32767;
      2:       return -1;
      default: return 0;
    endcase
  endfunction

  initial begin
    int sx [5];
    int sy [5];
    int k;
    sx = '{79, 28, -292, -663, -23};
    sy = '{-253, -620, -737, -212, 136};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: corners and extremes of both fields
    send_position(-32768, -32768); idle_gap();
    send_position(32767, 32767);   idle_gap();
    send_position(32767, -32768);  idle_gap();
    send_position(-32768, 32767);  idle_gap();
    send_position(0, 0);           idle_gap();
    send_position(-1, -1);         idle_gap();
    send_position(21845, -21846);  idle_gap();
    send_position(-21846, 21845);  idle_gap();
    // Directed: exactly on each landmark, then one step off
    for (int i = 0; i < 5; i++) begin
      send_position(sx[i], sy[i]);         idle_gap();
      send_position(sx[i] + 1, sy[i] - 1); idle_gap();
    end
    // Directed: equal distances, lower index must win (cube/dumpster, cylinder/barrier)
    send_position(-130, -411); idle_gap();
    send_position(-440, -448); idle_gap();

    // Random positions
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      k = $urandom_range(0, 4);
      send_position(pick_coord(sx[k]), pick_coord(sy[k]));
      idle_gap();
    end
    start <= 1'b0;

    // Drain the pipeline
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/nls_pkg.sv
sv/nls_cell.sv
sv/nls_root_cell.sv
sv/nearest_landmark_search.sv
tb/nearest_landmark_search_checker.sv
tb/nearest_landmark_search_tb.sv
